// ===== hdl/tvnf_pkg.sv =====
// shared types, constants and character codes for the text visualize number filter
package tvnf_pkg;

  // line number digits and derived widths
  localparam int NUMBER_DIGITS = 6;
  localparam int NUM_W         = 4 * NUMBER_DIGITS;
  localparam int GLYPH_MAX     = 4;
  localparam int MAX_RESULTS   = NUMBER_DIGITS + 1 + GLYPH_MAX;
  localparam int POS_W         = $clog2(MAX_RESULTS + 1);
  localparam int GCNT_W        = 3;

  // item queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // register port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = ADDR_W - 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SHOW_ENDS        = 3'd2;
  localparam logic [IDX_W-1:0] REG_SHOW_TABS        = 3'd3;
  localparam logic [IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

  // numbering modes
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_ALL      = 2'd1;
  localparam logic [1:0] MODE_NONBLANK = 2'd2;

  // newline run saturation
  localparam logic [1:0] RUN_MAX = 2'd3;
  localparam logic [1:0] RUN_BLANK_LIMIT = 2'd2;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [6:0] CH_DEL7   = 7'h7F;
  localparam logic [7:0] CTRL_OFS  = 8'd64;
  localparam logic [6:0] CTRL_LIM7 = 7'd32;

  // configuration seen by the datapath
  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blank;
    logic       show_ends;
    logic       show_tabs;
    logic       show_nonprinting;
  } cfg_t;

  // one classified item: optional number prefix plus up to four glyph bytes
  typedef struct packed {
    logic [NUM_W-1:0]           number;
    logic [NUMBER_DIGITS-1:0]   blank;
    logic                       has_number;
    logic [GLYPH_MAX-1:0][7:0]  glyph;
    logic [GCNT_W-1:0]          glyph_cnt;
  } item_t;

endpackage

// ===== hdl/tvnf_regs.sv =====
// configuration register file behind the apb-style port
module tvnf_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tvnf_pkg::ADDR_W-1:0] paddr,
  input  logic [tvnf_pkg::DATA_W-1:0] pwdata,
  output logic [tvnf_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output tvnf_pkg::cfg_t              cfg
);
  import tvnf_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_NUMBER_MODE:      cfg.number_mode      <= pwdata[1:0];
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= pwdata[0];
        REG_SHOW_ENDS:        cfg.show_ends        <= pwdata[0];
        REG_SHOW_TABS:        cfg.show_tabs        <= pwdata[0];
        REG_SHOW_NONPRINTING: cfg.show_nonprinting <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_NUMBER_MODE:      prdata = DATA_W'(cfg.number_mode);
      REG_SQUEEZE_BLANK:    prdata = DATA_W'(cfg.squeeze_blank);
      REG_SHOW_ENDS:        prdata = DATA_W'(cfg.show_ends);
      REG_SHOW_TABS:        prdata = DATA_W'(cfg.show_tabs);
      REG_SHOW_NONPRINTING: prdata = DATA_W'(cfg.show_nonprinting);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== hdl/tvnf_front.sv =====
// front end: accepts input bytes, tracks line state and classifies each byte
module tvnf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  tvnf_pkg::cfg_t       cfg,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,
  input  logic                 full,
  output logic                 push,
  output tvnf_pkg::item_t      push_item
);
  import tvnf_pkg::*;

  // bcd increment that holds at all nines
  function automatic logic [NUM_W-1:0] bcd_advance(input logic [NUM_W-1:0] v);
    logic [NUM_W-1:0] r;
    logic             carry;
    logic             all9;
    r     = v;
    carry = 1'b1;
    all9  = 1'b1;
    for (int d = 0; d < NUMBER_DIGITS; d++) begin
      if (v[4*d +: 4] != 4'd9) all9 = 1'b0;
      if (carry) begin
        if (v[4*d +: 4] >= 4'd9) begin
          r[4*d +: 4] = 4'd0;
        end else begin
          r[4*d +: 4] = v[4*d +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (all9) r = v;
    return r;
  endfunction

  logic             after_newline;
  logic [1:0]       newline_run;
  logic [NUM_W-1:0] line_number;

  logic             accept;
  logic             nl;
  logic             line_start;
  logic [1:0]       newline_run_next;
  logic             drop;
  logic             numbered;
  logic [7:0]       b;
  logic [6:0]       c7;
  logic [7:0]       t0;
  logic [7:0]       t1;
  logic [GCNT_W-1:0] tn;
  logic             lead;

  assign s_tready   = !full;
  assign accept     = s_tvalid && s_tready;
  assign b          = s_tdata;
  assign c7         = b[6:0];
  assign nl         = (b == CH_NL);
  assign line_start = after_newline;

  // newline run and squeeze decision
  always_comb begin
    if (!nl) begin
      newline_run_next = line_start ? 2'd0 : newline_run;
    end else if (newline_run < RUN_MAX) begin
      newline_run_next = newline_run + 2'd1;
    end else begin
      newline_run_next = newline_run;
    end
  end

  assign drop     = cfg.squeeze_blank && (newline_run_next > RUN_BLANK_LIMIT);
  assign numbered = line_start && !drop &&
                    ((cfg.number_mode == MODE_ALL) ||
                     ((cfg.number_mode == MODE_NONBLANK) && !nl));
  assign push     = accept && !drop;

  // caret form of the low seven bits
  always_comb begin
    if (c7 < CTRL_LIM7) begin
      t0 = CH_CARET;
      t1 = 8'(c7) + CTRL_OFS;
      tn = GCNT_W'(2);
    end else if (c7 == CH_DEL7) begin
      t0 = CH_CARET;
      t1 = CH_QUEST;
      tn = GCNT_W'(2);
    end else begin
      t0 = 8'(c7);
      t1 = 8'h00;
      tn = GCNT_W'(1);
    end
  end

  // glyph bytes for the input byte
  always_comb begin
    push_item.glyph     = '0;
    push_item.glyph_cnt = GCNT_W'(1);
    if (nl) begin
      if (cfg.show_ends) begin
        push_item.glyph[0]  = CH_DOLLAR;
        push_item.glyph[1]  = CH_NL;
        push_item.glyph_cnt = GCNT_W'(2);
      end else begin
        push_item.glyph[0]  = CH_NL;
      end
    end else if (b == CH_TAB) begin
      if (cfg.show_tabs) begin
        push_item.glyph[0]  = CH_CARET;
        push_item.glyph[1]  = CH_I;
        push_item.glyph_cnt = GCNT_W'(2);
      end else begin
        push_item.glyph[0]  = CH_TAB;
      end
    end else if (!cfg.show_nonprinting) begin
      push_item.glyph[0] = b;
    end else if (b[7]) begin
      push_item.glyph[0]  = CH_M;
      push_item.glyph[1]  = CH_DASH;
      push_item.glyph[2]  = t0;
      push_item.glyph[3]  = t1;
      push_item.glyph_cnt = GCNT_W'(2) + tn;
    end else begin
      push_item.glyph[0]  = t0;
      push_item.glyph[1]  = t1;
      push_item.glyph_cnt = tn;
    end
  end

  // number prefix with leading zeros marked blank
  always_comb begin
    lead = 1'b1;
    push_item.blank = '0;
    for (int d = NUMBER_DIGITS - 1; d >= 0; d--) begin
      if (line_number[4*d +: 4] != 4'd0 || d == 0) lead = 1'b0;
      push_item.blank[d] = lead;
    end
    push_item.number     = line_number;
    push_item.has_number = numbered;
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      after_newline <= 1'b1;
      newline_run   <= 2'd1;
      line_number   <= NUM_W'(1);
    end else if (accept) begin
      after_newline <= nl;
      newline_run   <= newline_run_next;
      if (numbered) line_number <= bcd_advance(line_number);
    end
  end

endmodule

// ===== hdl/tvnf_queue.sv =====
// short item queue between the front and back ends
module tvnf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tvnf_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output tvnf_pkg::item_t head,
  output logic            empty
);
  import tvnf_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + (QPTR_W+1)'(1);
      else if (pop && !push) count <= count - (QPTR_W+1)'(1);
    end
  end

endmodule

// ===== hdl/tvnf_back.sv =====
// back end: expands the head item into output bytes, one per unstalled cycle
module tvnf_back (
  input  logic            clk,
  input  logic            rst,
  input  tvnf_pkg::item_t head,
  input  logic            empty,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);
  import tvnf_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] gpos;
  logic [7:0]       cur_byte;
  logic             is_last;
  logic             load;
  logic             emit;
  logic [3:0]       digit;
  logic             digit_blank;

  // byte count of the head item
  assign total = (head.has_number ? POS_W'(NUMBER_DIGITS + 1) : POS_W'(0)) +
                 POS_W'(head.glyph_cnt);
  assign gpos    = head.has_number ? pos - POS_W'(NUMBER_DIGITS + 1) : pos;
  assign is_last = (pos == total - POS_W'(1));

  // digit at the current column
  always_comb begin
    digit       = 4'd0;
    digit_blank = 1'b0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (pos == POS_W'(i)) begin
        digit       = head.number[4*(NUMBER_DIGITS-1-i) +: 4];
        digit_blank = head.blank[NUMBER_DIGITS-1-i];
      end
    end
  end

  // byte at the current position
  always_comb begin
    if (head.has_number && pos < POS_W'(NUMBER_DIGITS)) begin
      cur_byte = digit_blank ? CH_SPACE : (CH_ZERO + 8'(digit));
    end else if (head.has_number && pos == POS_W'(NUMBER_DIGITS)) begin
      cur_byte = CH_TAB;
    end else begin
      cur_byte = head.glyph[gpos[$clog2(GLYPH_MAX)-1:0]];
    end
  end

  assign load = !m_tvalid || m_tready;
  assign emit = load && !empty;
  assign pop  = emit && is_last;

  // position within the item
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (emit) begin
      pos <= is_last ? '0 : pos + POS_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= cur_byte;
      m_tlast <= is_last;
    end
  end

  // an idle back end sits at the first byte
  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    empty |-> pos == '0)
    else $error("back end position not cleared while queue empty");

  // the position never runs past the item
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> pos < total)
    else $error("back end position beyond item length");

  // finishing an item restarts at its first byte and shows the final flag
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> pos == '0 && m_tvalid && m_tlast)
    else $error("item end not marked on the output");

endmodule

// ===== hdl/text_visualize_number_filter.sv =====
// top level of the text visualize number filter
// Renders a text byte stream the way a cat-style tool does with its display
// options: optional right-aligned six-digit line numbers and a tab before each
// line (all lines or non-blank ones), squeezing of blank line runs, '$' before
// newlines, '^I' for tabs and caret / M- notation for control and high bytes.
// Each input byte yields one to eleven output bytes, the last one marked with
// m_tlast; a squeezed blank line yields none and a numbered line start adds
// seven. The output register emits one byte per cycle, also for bytes that
// render to one byte, unless m_tready stalls it or the queue is empty. A
// four-item queue sits between the classifier and the expander, so input is
// accepted while an expansion is still being sent. Registers are to be
// written through the APB-style port while the stream is idle; the block does
// not enforce this. s_tlast marks file ends and does not change the rendering.
module text_visualize_number_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // in_byte
  input  logic                        s_tlast,   // end_of_file
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // out_byte
  output logic                        m_tlast,   // last
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tvnf_pkg::ADDR_W-1:0] paddr,
  input  logic [tvnf_pkg::DATA_W-1:0] pwdata,
  output logic [tvnf_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tvnf_pkg::*;

  cfg_t  cfg;
  item_t push_item;
  item_t head;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;

  // configuration registers
  tvnf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // classifier and line state
  tvnf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  // item queue
  tvnf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  // byte expander
  tvnf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
